@@ sv/lsb_stego_text_extractor_top_macros.svh @@
// Assertion macros shared by the text extractor modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef LSB_STEGO_TEXT_EXTRACTOR_TOP_MACROS_SVH
`define LSB_STEGO_TEXT_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define LSBX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define LSBX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lsbx_pkg.sv @@
// Shared types and constants of the LSB text extractor.
// No dependencies; used by the front, queue, back and top modules.
package lsbx_pkg;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_IDLE   = 2'd2;

    localparam logic [2:0] HDR_LAST  = 3'd7;
    localparam logic [3:0] MAX_BITS  = 4'd8;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] text_byte;
        logic       message_end;
        logic       header_bad;
        logic       truncated;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

@@ sv/lsbx_front.sv @@
// Front end of the extractor: accepts carrier bytes, parses header and data bits.
// Depends on lsbx_pkg and the assertion macros header.
`include "lsb_stego_text_extractor_top_macros.svh"

module lsbx_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          carrier_byte,
    input  logic                frame_start,
    input  logic                last_byte,
    input  lsbx_pkg::fifo_stat_t stat,
    output logic                push,
    output lsbx_pkg::result_t   push_data
);

    logic [1:0] phase_reg, phase_next;
    logic [2:0] hcount_reg, hcount_next;
    logic [7:0] bpc_reg, bpc_next;
    logic [7:0] acc_reg, acc_next;
    logic [2:0] bits_reg, bits_next;

    logic [1:0]  phase_eff;
    logic [2:0]  hcount_eff;
    logic [7:0]  bpc_eff;
    logic [7:0]  acc_eff;
    logic [2:0]  bits_eff;
    logic [7:0]  bpc_hdr;
    logic [3:0]  n_use;
    logic [4:0]  fill_sum;
    logic [3:0]  take;
    logic        complete;
    logic [7:0]  rev;
    logic [15:0] shifted;
    logic        accept;
    lsbx_pkg::result_t res;

    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            rev[7 - i] = carrier_byte[i];
        end
    end

    always_comb
    begin
        // A frame start restarts parsing before this byte is looked at.
        phase_eff  = frame_start ? lsbx_pkg::PH_HEADER : phase_reg;
        hcount_eff = frame_start ? 3'd0 : hcount_reg;
        bpc_eff    = frame_start ? 8'd0 : bpc_reg;
        acc_eff    = frame_start ? 8'd0 : acc_reg;
        bits_eff   = frame_start ? 3'd0 : bits_reg;

        bpc_hdr  = bpc_eff | ({7'd0, carrier_byte[0]} << hcount_eff);
        n_use    = (bpc_eff > {4'd0, lsbx_pkg::MAX_BITS}) ? lsbx_pkg::MAX_BITS : bpc_eff[3:0];
        fill_sum = {2'd0, bits_eff} + {1'b0, n_use};
        complete = fill_sum >= {1'b0, lsbx_pkg::MAX_BITS};
        take     = complete ? (lsbx_pkg::MAX_BITS - {1'b0, bits_eff}) : n_use;
        shifted  = {acc_eff, rev} << take;

        phase_next  = phase_eff;
        hcount_next = hcount_eff;
        bpc_next    = bpc_eff;
        acc_next    = acc_eff;
        bits_next   = bits_eff;
        res         = '0;

        case (phase_eff)
            lsbx_pkg::PH_HEADER:
            begin
                bpc_next = bpc_hdr;
                if (hcount_eff == lsbx_pkg::HDR_LAST)
                begin
                    hcount_next = 3'd0;
                    if (bpc_hdr == 8'd0 || bpc_hdr > {4'd0, lsbx_pkg::MAX_BITS})
                    begin
                        res.header_bad = 1'b1;
                        phase_next     = lsbx_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = lsbx_pkg::PH_DATA;
                    end
                end
                else
                begin
                    hcount_next = hcount_eff + 3'd1;
                end
            end
            lsbx_pkg::PH_DATA:
            begin
                if (complete)
                begin
                    // Bits left in the carrier byte after a completed byte are dropped.
                    acc_next      = 8'd0;
                    bits_next     = 3'd0;
                    res.text_byte = shifted[15:8];
                    if (shifted[15:8] == 8'd0)
                    begin
                        res.message_end = 1'b1;
                        phase_next      = lsbx_pkg::PH_IDLE;
                    end
                    else
                    begin
                        res.byte_valid = 1'b1;
                    end
                end
                else
                begin
                    acc_next  = shifted[15:8];
                    bits_next = fill_sum[2:0];
                end
            end
            default:
            begin
                phase_next = phase_eff;
            end
        endcase

        if (last_byte && (phase_next == lsbx_pkg::PH_HEADER ||
                          phase_next == lsbx_pkg::PH_DATA || res.header_bad))
        begin
            res.truncated = 1'b1;
            phase_next    = lsbx_pkg::PH_IDLE;
        end
    end

    assign push      = accept && (res.byte_valid || res.message_end ||
                                  res.header_bad || res.truncated);
    assign push_data = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lsbx_pkg::PH_HEADER;
            hcount_reg <= 3'd0;
            bpc_reg    <= 8'd0;
            acc_reg    <= 8'd0;
            bits_reg   <= 3'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            bpc_reg    <= bpc_next;
            acc_reg    <= acc_next;
            bits_reg   <= bits_next;
        end
    end

    `LSBX_ASSERT_NOW(a_valid_end_excl, push, !(push_data.byte_valid && push_data.message_end), "byte_valid and message_end together")
    `LSBX_ASSERT_NOW(a_end_zero, push && push_data.message_end, push_data.text_byte == 8'd0, "terminator with nonzero byte")
    `LSBX_ASSERT_NOW(a_data_count_ok, phase_reg == lsbx_pkg::PH_DATA, bpc_reg != 8'd0 && bpc_reg <= 8'd8, "data phase with bad count")

endmodule

@@ sv/lsbx_fifo.sv @@
// Short result queue between the parser front end and the output stage.
// Depends on lsbx_pkg and the assertion macros header.
`include "lsb_stego_text_extractor_top_macros.svh"

module lsbx_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lsbx_pkg::result_t    push_data,
    input  logic                 pop,
    output lsbx_pkg::result_t    rd_data,
    output lsbx_pkg::fifo_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lsbx_pkg::result_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LSBX_ASSERT_NOW(a_no_overflow, push, !stat.full || pop, "push into full queue")
    `LSBX_ASSERT_NOW(a_no_underflow, pop, !stat.empty, "pop from empty queue")

endmodule

@@ sv/lsbx_back.sv @@
// Output stage: moves queued results into the output register and holds them.
// Depends on lsbx_pkg.
module lsbx_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lsbx_pkg::fifo_stat_t stat,
    input  lsbx_pkg::result_t    rd_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lsbx_pkg::result_t    result
);

    logic              valid_reg;
    lsbx_pkg::result_t result_reg;

    assign pop       = !stat.empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= !stat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= rd_data;
        end
    end

endmodule

@@ sv/lsb_stego_text_extractor_top.sv @@
// Top level of the LSB steganography text extractor.
// Depends on lsbx_pkg, lsbx_front, lsbx_fifo and lsbx_back.
//
// Usage: image data bytes enter one request at a time on the input channel
// (in_valid/in_ready with carrier_byte, frame_start, last_byte). Raise
// frame_start on the first byte of a frame. The first eight bytes form the
// header whose bit 0 values give the bits-per-carrier count, LSB first; each
// later byte contributes its low bits, bit 0 first, which are packed MSB first
// into text bytes. Results leave on the output channel (out_valid/out_ready):
// a recovered byte, the terminator, a bad header or a truncated frame.
// Bytes that complete nothing produce no result.
// Throughput is one request per cycle while in_ready is high; the parser
// decodes a whole carrier byte combinationally. The edge that accepts a
// request writes its result into the queue; the output register then loads
// it from the queue once it is empty or its result is being taken, and
// out_valid rises with that load.
// Reset clears the parser to the header phase and empties the queue and the
// output register. When the receiver stalls, the output register holds its
// result and the queue absorbs up to FIFO_DEPTH more; once it is full,
// in_ready drops, and it rises again in the cycle after the receiver takes a
// result.
module lsb_stego_text_extractor_top #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] carrier_byte,
    input  logic       frame_start,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       byte_valid,
    output logic [7:0] text_byte,
    output logic       message_end,
    output logic       header_bad,
    output logic       truncated
);

    lsbx_pkg::fifo_stat_t stat;
    lsbx_pkg::result_t    push_data;
    lsbx_pkg::result_t    rd_data;
    lsbx_pkg::result_t    result;
    logic                 push;
    logic                 pop;

    // Front end: parses each accepted byte and queues any result it causes.
    lsbx_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .carrier_byte (carrier_byte),
        .frame_start  (frame_start),
        .last_byte    (last_byte),
        .stat         (stat),
        .push         (push),
        .push_data    (push_data)
    );

    // Queue that lets the parser keep going while the receiver stalls.
    lsbx_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .rd_data   (rd_data),
        .stat      (stat)
    );

    // Back end: registered output channel.
    lsbx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .rd_data   (rd_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign byte_valid  = result.byte_valid;
    assign text_byte   = result.text_byte;
    assign message_end = result.message_end;
    assign header_bad  = result.header_bad;
    assign truncated   = result.truncated;

endmodule

@@ test/lsb_stego_text_extractor_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for lsb_stego_text_extractor_top.
// Depends on lsbx_pkg and the extractor RTL. Predicts every result from the
// stream of accepted requests and compares it with what leaves the block.
module lsb_stego_text_extractor_top_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int NO_IDLE_ITEMS  = 300;
    localparam int IDLE_PCT       = 22;
    localparam int RX_HOLD_CYCLES = 150;
    // Cycles waited after the drain, to catch any result that should not be there.
    localparam int DRAIN_SETTLE   = 10;
    localparam int CYCLE_LIMIT    = 400000;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] carrier_byte = 8'h00;
    logic       frame_start  = 1'b0;
    logic       last_byte    = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic       byte_valid;
    logic [7:0] text_byte;
    logic       message_end;
    logic       header_bad;
    logic       truncated;

    // Results that the decoder predicts, oldest first.
    lsbx_pkg::result_t awaited_results[$];
    lsbx_pkg::result_t due;

    // Decoder state, mirroring what the block keeps between requests.
    logic [1:0] parse_phase;
    logic [2:0] hdr_index;
    logic [7:0] carrier_bits;
    logic [7:0] text_acc;
    logic [2:0] text_nbits;

    int mismatches  = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // The receiver owns its hold counter; a test only bumps the request count.
    int rx_hold_req  = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;

    lsb_stego_text_extractor_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .carrier_byte (carrier_byte),
        .frame_start  (frame_start),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .byte_valid   (byte_valid),
        .text_byte    (text_byte),
        .message_end  (message_end),
        .header_bad   (header_bad),
        .truncated    (truncated)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold whenever a test asks for one.
    always @(posedge clk)
    begin
        if (rx_hold_seen != rx_hold_req)
        begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic void restart_decoder();
        parse_phase  = lsbx_pkg::PH_HEADER;
        hdr_index    = 3'd0;
        carrier_bits = 8'd0;
        text_acc     = 8'd0;
        text_nbits   = 3'd0;
    endfunction

    // Works out what one accepted carrier byte yields and queues the result.
    // The header's bit 0 values build the count LSB first; data bits enter the
    // text byte MSB first, and a byte is reported on its eighth bit.
    function automatic void decode_carrier(input logic [7:0] cb, input logic fs,
                                           input logic lb);
        lsbx_pkg::result_t r;
        int                n;
        bit                byte_done;

        r = '0;
        byte_done = 1'b0;
        if (fs)
            restart_decoder();

        if (parse_phase == lsbx_pkg::PH_HEADER)
        begin
            if (cb[0])
                carrier_bits[hdr_index] = 1'b1;
            if (hdr_index == lsbx_pkg::HDR_LAST)
            begin
                hdr_index = 3'd0;
                if (carrier_bits == 8'd0 || carrier_bits > lsbx_pkg::MAX_BITS)
                begin
                    r.header_bad = 1'b1;
                    parse_phase = lsbx_pkg::PH_IDLE;
                end
                else
                begin
                    parse_phase = lsbx_pkg::PH_DATA;
                end
            end
            else
            begin
                hdr_index = hdr_index + 3'd1;
            end
        end
        else if (parse_phase == lsbx_pkg::PH_DATA)
        begin
            n = (carrier_bits > lsbx_pkg::MAX_BITS) ? 8 : int'(carrier_bits);
            // Bits beyond a completed byte in the same carrier are dropped.
            for (int i = 0; i < n && !byte_done; i++)
            begin
                text_acc = {text_acc[6:0], cb[i]};
                if (text_nbits == 3'd7)
                begin
                    byte_done   = 1'b1;
                    text_nbits  = 3'd0;
                    r.text_byte = text_acc;
                    text_acc    = 8'd0;
                    if (r.text_byte == 8'd0)
                    begin
                        r.message_end = 1'b1;
                        parse_phase = lsbx_pkg::PH_IDLE;
                    end
                    else
                    begin
                        r.byte_valid = 1'b1;
                    end
                end
                else
                begin
                    text_nbits = text_nbits + 3'd1;
                end
            end
        end

        // A last byte before the terminator cuts the frame short; a bad header
        // on the same byte shares the result.
        if (lb && (parse_phase == lsbx_pkg::PH_HEADER ||
                   parse_phase == lsbx_pkg::PH_DATA || r.header_bad))
        begin
            r.truncated = 1'b1;
            parse_phase = lsbx_pkg::PH_IDLE;
        end

        if (r.byte_valid || r.message_end || r.header_bad || r.truncated)
            awaited_results.push_back(r);
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want_v,
                                          input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // Result checker: every accepted result must match the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: byte_valid %0d text_byte %0h", byte_valid,
                       text_byte);
                mismatches++;
            end
            else
            begin
                due = awaited_results.pop_front();
                compare_field("byte_valid", 8'(due.byte_valid), 8'(byte_valid));
                compare_field("text_byte", due.text_byte, text_byte);
                compare_field("message_end", 8'(due.message_end), 8'(message_end));
                compare_field("header_bad", 8'(due.header_bad), 8'(header_bad));
                compare_field("truncated", 8'(due.truncated), 8'(truncated));
            end
        end
    end

    // Offers one request, after idle cycles drawn one at a time, and returns
    // at the edge where it is taken. in_valid stays high so that a following
    // request can go out back to back.
    task automatic send_carrier(input logic [7:0] cb, input logic fs, input logic lb);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        in_valid     <= 1'b1;
        carrier_byte <= cb;
        frame_start  <= fs;
        last_byte    <= lb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_carrier(cb, fs, lb);
        items_sent++;
    endtask

    // Drops in_valid and waits until every predicted result has been taken.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Builds one frame: a header carrying the count, then random nonzero text
    // packed count bits per carrier (eight for a count outside 1 to 8), an optional terminator and some padding.
    // Only the first keep bytes go out when keep is not negative.
    task automatic send_frame(input logic [7:0] count, input int n_chars,
                              input bit with_term, input int pad, input bit start_flag,
                              input bit mark_last, input int keep);
        logic [7:0] frame_bytes[$];
        bit         text_bits[$];
        logic [7:0] cb;
        logic [7:0] ch;
        int         n;
        int         limit;

        for (int i = 0; i < 8; i++)
        begin
            cb = 8'($urandom_range(0, 255));
            cb[0] = count[i];
            frame_bytes.push_back(cb);
        end
        n = (count == 8'd0 || count > lsbx_pkg::MAX_BITS) ? 8 : int'(count);
        for (int c = 0; c < n_chars; c++)
        begin
            ch = 8'($urandom_range(1, 255));
            for (int b = 7; b >= 0; b--)
                text_bits.push_back(ch[b]);
        end
        if (with_term)
            repeat (8) text_bits.push_back(1'b0);
        // Unused high bits of a carrier, and the tail of the last one, are noise.
        while (text_bits.size() > 0)
        begin
            cb = 8'($urandom_range(0, 255));
            for (int i = 0; i < n && text_bits.size() > 0; i++)
                cb[i] = text_bits.pop_front();
            frame_bytes.push_back(cb);
        end
        repeat (pad) frame_bytes.push_back(8'($urandom_range(0, 255)));

        limit = (keep < 0 || keep > frame_bytes.size()) ? frame_bytes.size() : keep;
        for (int k = 0; k < limit; k++)
            send_carrier(frame_bytes[k], (k == 0) ? start_flag : 1'b0,
                         mark_last && (k == limit - 1));
    endtask

    // All-ones header gives a count of 255, all-zeros a count of 0; both are
    // rejected. A byte in the idle phase is ignored even with last_byte set,
    // while last_byte on the rejecting header byte shares its result.
    task automatic test_bad_headers();
        for (int i = 0; i < 8; i++)
            send_carrier(8'hFF, i == 0, 1'b0);
        send_carrier(8'h00, 1'b0, 1'b1);
        for (int i = 0; i < 8; i++)
            send_carrier(8'h00, i == 0, i == 7);
    endtask

    // A count of 8 takes a whole text byte from each carrier: 0xFF comes out
    // as text, 0x00 ends the message, and the byte after it is ignored.
    task automatic test_full_width_text();
        for (int i = 0; i < 8; i++)
            send_carrier((i == 3) ? 8'h01 : 8'h00, i == 0, 1'b0);
        send_carrier(8'hFF, 1'b0, 1'b0);
        send_carrier(8'h00, 1'b0, 1'b0);
        send_carrier(8'hA5, 1'b0, 1'b1);
    endtask

    // Last byte in the data phase with a partial text byte, then last byte in
    // the middle of a header.
    task automatic test_truncation();
        send_frame(8'd3, 1, 1'b0, 0, 1'b1, 1'b1, 10);
        send_frame(8'd5, 0, 1'b0, 0, 1'b1, 1'b1, 4);
    endtask

    // The receiver holds off while a long full-width message streams in, so
    // the queue fills and in_ready must drop. Then the sender waits for every
    // result before going on.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req++;
        send_frame(8'd8, 24, 1'b1, 0, 1'b1, 1'b0, -1);
        wait_for_drain();
    endtask

    // Mostly well-formed frames with random counts and text, plus cut frames,
    // rejected headers and loose bytes with random flags. The first stretch
    // runs with no idling on either side.
    task automatic test_random_frames();
        int kind;
        int stop_at;
        int no_idle_until;
        int n_chars;

        stop_at = items_sent + RANDOM_ITEMS;
        no_idle_until = items_sent + NO_IDLE_ITEMS;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (items_sent < stop_at)
        begin
            if (items_sent >= no_idle_until)
            begin
                tx_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end
            kind = $urandom_range(0, 99);
            n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                  : $urandom_range(0, 5);
            if (kind < 65)
                send_frame(8'($urandom_range(1, 8)), n_chars, $urandom_range(0, 9) != 0,
                           $urandom_range(0, 3), $urandom_range(0, 19) != 0,
                           $urandom_range(0, 1) == 1, -1);
            else if (kind < 77)
                send_frame(8'($urandom_range(1, 8)), n_chars, 1'b1, 0, 1'b1,
                           $urandom_range(0, 1) == 1, $urandom_range(1, 20));
            else if (kind < 87)
                send_frame(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(9, 255)),
                           $urandom_range(0, 2), 1'b1, $urandom_range(0, 2), 1'b1,
                           $urandom_range(0, 1) == 1, -1);
            else
                repeat ($urandom_range(1, 8))
                    send_carrier(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                                 $urandom_range(0, 6) == 0);
            // Now and then let everything drain mid-stream.
            if ($urandom_range(0, 49) == 0)
                wait_for_drain();
        end
    endtask

    initial
    begin
        restart_decoder();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
        test_bad_headers();
        test_full_width_text();
        test_truncation();
        test_backpressure();
        test_random_frames();

        wait_for_drain();
        repeat (DRAIN_SETTLE) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ lsb_stego_text_extractor_top.f @@
+incdir+sv
sv/lsbx_pkg.sv
sv/lsbx_front.sv
sv/lsbx_fifo.sv
sv/lsbx_back.sv
sv/lsb_stego_text_extractor_top.sv
test/lsb_stego_text_extractor_top_tb.sv
